>>> src/ras_pkg.sv
// Shared types and constants for the running average smoother.
// No dependencies.
package ras_pkg;

  localparam int unsigned DATA_W    = 16;  // sample and average width
  localparam int unsigned CFG_W     = 8;   // window length register width
  localparam int unsigned WIN_RESET = 16;  // window length after reset

  typedef enum logic [1:0] {
    S_IDLE,  // waiting for a sample request
    S_READ,  // read oldest entry, kick divider
    S_SUB,   // retire oldest entry from the total
    S_DIV    // wait for quotient and a free output slot
  } ras_state_e;

endpackage

>>> src/ras_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Depends on ras_pkg.
module ras_div #(
  parameter int unsigned TOT_W = 23,
  parameter int unsigned CNT_W = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [TOT_W-1:0]           dividend_i,
  input  logic        [CNT_W-1:0]           divisor_i,
  output logic                              done_o,
  output logic signed [ras_pkg::DATA_W-1:0] quotient_o
);
  import ras_pkg::*;

  localparam int unsigned STEP_W = $clog2(TOT_W + 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [TOT_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;
  logic [DATA_W-1:0] mag;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[TOT_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = (rem_sh >= {1'b0, dvs_q});

    run_d  = run_q;
    done_d = done_q;
    neg_d  = neg_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;

    if (start_i) begin
      run_d  = 1'b1;
      done_d = 1'b0;
      neg_d  = dividend_i[TOT_W-1];
      dvd_d  = dividend_i[TOT_W-1] ? TOT_W'(-dividend_i) : TOT_W'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = STEP_W'(TOT_W);
    end else if (run_q) begin
      rem_d  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_d  = {dvd_q[TOT_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // quotient magnitude of 16-bit samples always fits in DATA_W bits
  assign mag        = dvd_q[DATA_W-1:0];
  assign quotient_o = neg_q ? DATA_W'(-mag) : mag;
  assign done_o     = done_q;

  a_done_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q)
    else $error("divider done while still iterating");

  a_done_after_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(run_q) && $past(step_q == STEP_W'(1)))
    else $error("divider finished early");

  a_no_divide_by_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> dvs_q != '0)
    else $error("divider started with zero divisor");

endmodule

>>> src/running_average_smoother_top.sv
// Running average smoother: top level with sample ring memory and sequencer.
// Depends on ras_pkg and ras_div.
//
// Usage:
//  - Input channel: in_valid_i / in_stall_o / sample_i. A sample request is
//    taken at a clock edge with in_valid_i high and in_stall_o low.
//  - Output channel: out_valid_o / out_stall_i / average_o. One average per
//    sample, the running total of the held samples divided by how many are
//    held (up to the window length), truncated toward zero.
//  - Config channel: cfg_valid_i / cfg_ready_o / window_length_i. A write
//    clamps the value into 1..MAX_WINDOW and restarts the window (total,
//    fill count and ring pointer go back to zero). Write only while idle.
//  - Sequence: an accepted sample passes through S_READ, S_SUB and S_DIV;
//    the next is taken back in S_IDLE, as the average enters the output slot.
//    The bit-serial divider (TOT_W = 7 + 16 = 23 bits for the default
//    MAX_WINDOW) paces S_DIV; one ring memory write plus one read per sample.
//  - The output register decouples the sides: the next sample is accepted
//    while an average waits; a stalled receiver only holds the block back
//    once the next quotient is ready and the slot is still full.
//  - Reset: window length 16 (clamped to MAX_WINDOW), empty window. The ring
//    memory is not cleared; the fill count masks entries not yet written.
module running_average_smoother_top #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ras_pkg::DATA_W-1:0] sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ras_pkg::DATA_W-1:0] average_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic        [ras_pkg::CFG_W-1:0]  window_length_i
);
  import ras_pkg::*;

  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TOT_W = DATA_W + CNT_W;
  localparam logic [CNT_W-1:0] WinInit =
    CNT_W'((WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET);

  ras_state_e state_q, state_d;

  logic        [CNT_W-1:0]  win_q, win_d;
  logic        [IDX_W-1:0]  idx_q, idx_d;
  logic        [CNT_W-1:0]  fill_q, fill_d;
  logic signed [TOT_W-1:0]  total_q, total_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] average_q, average_d;

  // sample ring memory, one write and one registered read per sample
  logic signed [DATA_W-1:0] ring_mem [MAX_WINDOW];
  logic signed [DATA_W-1:0] rd_data_q;

  logic              in_acc, cfg_acc, rd_en, div_start, div_done, out_load;
  logic [CNT_W-1:0]  win_clamped;
  logic [CNT_W-1:0]  idx_inc;
  logic signed [DATA_W-1:0] quotient;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign idx_inc = CNT_W'(idx_q) + CNT_W'(1);

  always_comb begin
    if (window_length_i == '0) begin
      win_clamped = CNT_W'(1);
    end else if (window_length_i > CFG_W'(MAX_WINDOW)) begin
      win_clamped = CNT_W'(MAX_WINDOW);
    end else begin
      win_clamped = CNT_W'(window_length_i);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_READ;
      end
      S_READ: state_d = S_SUB;
      S_SUB:  state_d = S_DIV;
      S_DIV: begin
        if (div_done && (!out_valid_q || !out_stall_i)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    rd_en       = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
      end
      S_READ: begin
        rd_en     = 1'b1;
        div_start = 1'b1;
      end
      S_SUB: ;
      S_DIV:  out_load = div_done && (!out_valid_q || !out_stall_i);
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    win_d       = win_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    average_d   = average_q;

    if (cfg_acc) begin
      win_d   = win_clamped;
      idx_d   = '0;
      fill_d  = '0;
      total_d = '0;
    end else if (in_acc) begin
      total_d = total_q + TOT_W'(sample_i);
      idx_d   = (idx_inc >= win_q) ? '0 : idx_inc[IDX_W-1:0];
      if (fill_q < win_q) fill_d = fill_q + CNT_W'(1);
    end else if (state_q == S_SUB && fill_q == win_q) begin
      // window full: the entry under the pointer is the oldest sample
      // (entries past the fill count may hold stale data and are not subtracted)
      total_d = total_q - TOT_W'(rd_data_q);
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      average_d   = quotient;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= WinInit;
      idx_q       <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      idx_q       <= idx_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    average_q <= average_d;
  end

  // write lands at accept; the read of the new pointer is registered in S_READ,
  // after the write, so a one-entry window sees the sample just written
  always_ff @(posedge clk_i) begin
    if (in_acc) ring_mem[idx_q] <= sample_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= ring_mem[idx_q];
  end

  ras_div #(
    .TOT_W (TOT_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_q)
    else $error("fill count beyond window length");

  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(idx_q) < win_q)
    else $error("ring pointer outside window");

  a_result_from_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_DIV) && $past(div_done))
    else $error("average presented without a finished division");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> fill_q != '0)
    else $error("division started with empty window");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for running_average_smoother_top: directed table, then random phases.
// Depends on ras_pkg and the running_average_smoother_top RTL; needs no files at run time.
`timescale 1ns / 100ps

module testbench;

  import ras_pkg::*;

  localparam int unsigned MAX_WIN      = 64;
  localparam int unsigned DRAIN_CYCLES = 30;        // idle margin after the last average is taken
  localparam int unsigned HOLD_CYCLES  = 400;       // one long receiver hold-off
  localparam int unsigned HOLD_AFTER   = 300;       // results taken before the hold-off
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned NUM_ROWS     = 29;
  localparam longint      TIMEOUT_NS   = 5_000_000;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_e;

  // One directed step: a sample request or a window write. Where the
  // average is obvious it is typed in, otherwise the model of the ring supplies it.
  typedef struct packed {
    row_kind_e         kind;
    logic [15:0]       value;
    logic              typed;
    logic [DATA_W-1:0] avg;
  } stim_row_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] sample_i        = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic signed [DATA_W-1:0] average_o;
  logic                     cfg_valid_i     = 1'b0;
  logic                     cfg_ready_o;
  logic        [CFG_W-1:0]  window_length_i = '0;

  // Model of the ring store and its running total.
  logic signed [DATA_W-1:0] ring [MAX_WIN];
  int unsigned              ring_pos;
  int unsigned              held;
  int unsigned              window;
  longint                   total;

  logic signed [DATA_W-1:0] pending_averages [$];
  int unsigned              mismatch_count;
  int unsigned              results_taken;
  int unsigned              burst_left;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // default window of 16 after reset
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF},  // first sample averages to itself
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h0000},  // -1/2 truncates toward zero
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'h0000},  // -2/3 as well
    '{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000},
    // zero window is treated as one
    '{ROW_WINDOW, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 16'h0000},
    '{ROW_WINDOW, 16'h0002, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h0000},  // oldest retired, -1/2 -> 0
    '{ROW_SAMPLE, 16'hFFFE, 1'b0, 16'h0000},
    // register maximum clamps to MAX_WIN
    '{ROW_WINDOW, 16'h00FF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, 16'h8001, 1'b0, 16'h0000},
    '{ROW_WINDOW, 16'h0041, 1'b0, 16'h0000},  // just above the maximum
    '{ROW_SAMPLE, 16'h1234, 1'b1, 16'h1234},  // write cleared the window
    '{ROW_WINDOW, 16'h0001, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h5555, 1'b1, 16'h5555},
    '{ROW_WINDOW, 16'h0040, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hAAAA, 1'b1, 16'hAAAA},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 16'h0000},
    '{ROW_WINDOW, 16'h0003, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'hFFFD, 1'b1, 16'hFFFD},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0002, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 16'h0007, 1'b0, 16'h0000}
  };

  running_average_smoother_top #(
    .MAX_WINDOW (MAX_WIN)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .average_o       (average_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .window_length_i (window_length_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Empty the window and take a new length, clamped into 1..MAX_WIN.
  function automatic void restart_window(input int unsigned len);
    window   = (len == 0) ? 1 : ((len > MAX_WIN) ? MAX_WIN : len);
    ring_pos = 0;
    held     = 0;
    total    = 0;
    for (int i = 0; i < MAX_WIN; i++) ring[i] = '0;
  endfunction

  // Store the sample, average what is held, then retire the entry now
  // under the ring pointer (zero while the window is still filling).
  function automatic logic signed [DATA_W-1:0] smooth_sample(
    input logic signed [DATA_W-1:0] s
  );
    longint quot;
    if (ring_pos >= MAX_WIN) ring_pos = 0;
    ring[ring_pos] = s;
    total += s;
    ring_pos++;
    if (ring_pos >= window) ring_pos = 0;
    if (held < window) held++;
    quot = total / longint'(held);
    total -= ring[ring_pos];
    return quot[DATA_W-1:0];
  endfunction

  // Extremes and small values weigh heavier than a flat spread would give.
  function automatic logic signed [DATA_W-1:0] pick_sample(input bit heavy);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (heavy && r < 3) r = $urandom_range(0, 1);
    case (r)
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return DATA_W'(int'($urandom_range(0, 16)) - 8);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Offer one sample request, possibly idling first when the current burst is used up.
  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic feed_sample(
    input logic signed [DATA_W-1:0] s,
    input logic                     typed,
    input logic signed [DATA_W-1:0] typed_avg
  );
    int unsigned              gap;
    logic signed [DATA_W-1:0] predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    predicted = smooth_sample(s);
    pending_averages.push_back(typed ? typed_avg : predicted);
  endtask

  // Window writes only once every average is out and the block is quiet.
  task automatic write_window(input logic [CFG_W-1:0] len);
    in_valid_i <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    window_length_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    restart_window(len);
    burst_left = 0;
  endtask

  // Compare every average taken with the oldest one predicted.
  always @(posedge clk_i) begin
    logic signed [DATA_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_taken++;
      if (pending_averages.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: average %0d with nothing pending", average_o);
      end else begin
        want = pending_averages.pop_front();
        if (average_o !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: average expected %0d, got %0d", want, average_o);
        end
      end
    end
  end

  // Receiver: random stall segments, plus one long hold-off so the output
  // slot fills and the block pushes back on its input.
  initial begin
    int unsigned mode;
    int unsigned len;
    bit          held_off;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_off && results_taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      len  = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(1, 60);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= $urandom_range(0, 1);
          default: out_stall_i <= 1'b1;
        endcase
        if (i != len - 1) @(posedge clk_i);
      end
    end
  end

  // Stimulus: directed table, then random phases each under a new window.
  initial begin
    int unsigned count;
    logic [CFG_W-1:0] len;
    mismatch_count = 0;
    results_taken  = 0;
    burst_left     = 0;
    restart_window(WIN_RESET);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WINDOW)
        write_window(directed_rows[i].value[CFG_W-1:0]);
      else
        feed_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].avg);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 5)
        0:       len = CFG_W'($urandom_range(0, 255));
        1:       len = CFG_W'($urandom_range(1, 8));
        2:       len = CFG_W'(MAX_WIN);
        3:       len = CFG_W'($urandom_range(MAX_WIN + 1, 255));
        default: len = CFG_W'($urandom_range(9, MAX_WIN - 1));
      endcase
      write_window(len);
      // one long full-window phase so the ring wraps a few times
      count = (p == 2) ? 150 : $urandom_range(50, 90);
      for (int n = 0; n < count; n++) feed_sample(pick_sample(p == 2), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_averages.size() == 0) begin
      $display("running_average_smoother_top verification clean");
    end else begin
      $display("running_average_smoother_top verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("running_average_smoother_top verification failed");
    $finish;
  end

endmodule

>>> running_average_smoother_top.f
src/ras_pkg.sv
src/ras_div.sv
src/running_average_smoother_top.sv
sim/testbench.sv
